@@ hw/rtl/wav_stream_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// wav_stream_parser_core_defines
// Assertion macros used by the WAV stream parser core.
// ----------------------------------------------------------------------------
`ifndef WAV_STREAM_PARSER_CORE_DEFINES_SVH
`define WAV_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WSP_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("wav stream parser assertion failed");

// next-cycle implication, disabled while in reset
`define WSP_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("wav stream parser assertion failed");

`endif

@@ hw/rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Types, status codes and tag constants of the WAV stream parser.
// ----------------------------------------------------------------------------
package wsp_pkg;

	typedef enum logic [2:0] {
		ST_SAMPLE      = 3'd0,
		ST_DONE        = 3'd1,
		ST_BAD_RIFF    = 3'd2,
		ST_BAD_WAVE    = 3'd3,
		ST_UNSUPPORTED = 3'd4,
		ST_TRUNCATED   = 3'd5,
		ST_EMPTY       = 3'd6
	} status_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	typedef struct packed {
		status_t     status;
		logic [31:0] sample_value;
		logic        is_float;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic        final_item;
	} result_t;

	function automatic logic [2:0] bytes_per_sample(input logic [15:0] fmt,
		input logic [15:0] bits);
		logic [2:0] n;
		n = 3'd0;
		if (fmt == FMT_PCM) begin
			if (bits == 16'd16) n = 3'd2;
			else if (bits == 16'd24) n = 3'd3;
			else if (bits == 16'd32) n = 3'd4;
		end else if (fmt == FMT_FLOAT) begin
			n = 3'd4;
		end
		return n;
	endfunction

endpackage

@@ hw/rtl/wav_stream_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_parser_core
// Byte-serial RIFF/WAVE parser: Q1.31 PCM or raw float samples, status codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel data_valid/data_stall carries one file byte per request,
//   with end_of_stream set on the last byte of the file.
//   Result channel result_valid/result_stall carries samples (status sample);
//   the last item, a terminal status or the last sample, sets final_item;
//   fmt fields ride along. A result is registered and appears in the cycle
//   after its byte is accepted. Throughput: one byte per cycle while the
//   input is not stalled.
//   The input stalls only while a held result is stalled by the receiver;
//   a held result is replaced the same cycle it is taken.
//   After the final item every byte is accepted and dropped until reset.
//   Reset returns the parser to the start of a file and empties the result
//   register.
// ----------------------------------------------------------------------------
`include "wav_stream_parser_core_defines.svh"

module wav_stream_parser_core import wsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic signed [31:0] sample_value,
	output logic        is_float,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic        final_item
);

	logic    accept;
	logic    res_valid;
	result_t res;
	logic    busy;
	result_t out_res;

	assign data_stall = busy;
	assign accept     = data_valid && !busy;

	wsp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.res_valid     (res_valid),
		.res           (res)
	);

	wsp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && res_valid),
		.load_res (res),
		.stall    (result_stall),
		.valid    (result_valid),
		.busy     (busy),
		.res      (out_res)
	);

	assign status        = out_res.status;
	assign sample_value  = out_res.sample_value;
	assign is_float      = out_res.is_float;
	assign format_tag    = out_res.format_tag;
	assign channel_count = out_res.channel_count;
	assign rate_hz       = out_res.rate_hz;
	assign sample_bits   = out_res.sample_bits;
	assign final_item    = out_res.final_item;

	`WSP_ASSERT_IMP(a_status_is_final, clk, arst_n, result_valid && (status != ST_SAMPLE), final_item)
	`WSP_ASSERT_IMP(a_float_on_sample, clk, arst_n, result_valid && is_float, status == ST_SAMPLE)
	`WSP_ASSERT_IMP(a_status_zero_value, clk, arst_n, result_valid && (status != ST_SAMPLE), sample_value == '0)
	`WSP_ASSERT_NXT(a_final_is_last, clk, arst_n, result_valid && !result_stall && final_item, !result_valid)

endmodule

@@ hw/rtl/wsp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_parser
// Chunk walker: holds the parse state and decides the result of each byte.
// ----------------------------------------------------------------------------
module wsp_parser import wsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        res_valid,
	output result_t     res
);

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_RSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_ID    = 4'd3,
		PH_SIZE  = 4'd4,
		PH_FMT   = 4'd5,
		PH_SKIP  = 4'd6,
		PH_PAD   = 4'd7,
		PH_DATA  = 4'd8,
		PH_IDLE  = 4'd9
	} phase_t;

	localparam logic [4:0] POS_SAT = 5'd16;

	phase_t      phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic        pad_q, pad_d;
	logic [31:0] chunk_q, chunk_d;
	logic [31:0] tag_q, tag_d;
	logic        have_fmt_q, have_fmt_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] smp_q, smp_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        given_q, given_d;

	logic        live;
	logic        term;
	status_t     term_st;
	logic        smp;
	logic        smp_final;
	logic [31:0] smp_val;
	logic [31:0] smp_new;
	logic [1:0]  cnt_new;
	logic [2:0]  bps;
	logic        boundary;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		pad_d      = pad_q;
		chunk_d    = chunk_q;
		tag_d      = tag_q;
		have_fmt_d = have_fmt_q;
		fmt_d      = fmt_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		bits_d     = bits_q;
		smp_d      = smp_q;
		cnt_d      = cnt_q;
		given_d    = given_q;
		live       = 1'b1;
		term       = 1'b0;
		term_st    = ST_DONE;
		smp        = 1'b0;
		smp_final  = 1'b0;
		smp_val    = smp_q;
		smp_new    = {data_byte, smp_q[31:8]};
		cnt_new    = cnt_q + 2'd1;
		bps        = bytes_per_sample(fmt_q, bits_q);
		boundary   = 1'b0;

		unique case (phase_q)
			PH_RIFF, PH_WAVE, PH_ID: begin
				tag_d = {tag_q[23:0], data_byte};
				if (pos_q == 5'd3) begin
					pos_d = 5'd0;
					if (phase_q == PH_RIFF) begin
						if (tag_d != TAG_RIFF) begin
							term    = 1'b1;
							term_st = ST_BAD_RIFF;
						end else begin
							phase_d = PH_RSIZE;
						end
					end else if (phase_q == PH_WAVE) begin
						if (tag_d != TAG_WAVE) begin
							term    = 1'b1;
							term_st = ST_BAD_WAVE;
						end else begin
							phase_d = PH_ID;
						end
					end else begin
						chunk_d = '0;
						phase_d = PH_SIZE;
					end
				end else begin
					pos_d = pos_q + 5'd1;
				end
			end
			PH_RSIZE: begin
				if (pos_q == 5'd3) begin
					pos_d   = 5'd0;
					phase_d = PH_WAVE;
				end else begin
					pos_d = pos_q + 5'd1;
				end
			end
			PH_SIZE: begin
				chunk_d = {data_byte, chunk_q[31:8]};
				if (pos_q == 5'd3) begin
					pos_d = 5'd0;
					pad_d = chunk_d[0];
					if (tag_q == TAG_FMT) begin
						have_fmt_d = 1'b1;
						fmt_d      = '0;
						chan_d     = '0;
						rate_d     = '0;
						bits_d     = '0;
						phase_d    = (chunk_d != '0) ? PH_FMT : PH_ID;
					end else if (tag_q == TAG_DATA && have_fmt_q) begin
						if (bps == 3'd0) begin
							term    = 1'b1;
							term_st = ST_UNSUPPORTED;
						end else if (chunk_d == '0) begin
							term    = 1'b1;
							term_st = ST_EMPTY;
						end else begin
							phase_d = PH_DATA;
							smp_d   = '0;
							cnt_d   = 2'd0;
						end
					end else begin
						phase_d = (chunk_d != '0) ? PH_SKIP : PH_ID;
					end
				end else begin
					pos_d = pos_q + 5'd1;
				end
			end
			PH_FMT, PH_SKIP: begin
				if (phase_q == PH_FMT) begin
					unique case (pos_q)
						5'd0:    fmt_d[7:0]    = data_byte;
						5'd1:    fmt_d[15:8]   = data_byte;
						5'd2:    chan_d[7:0]   = data_byte;
						5'd3:    chan_d[15:8]  = data_byte;
						5'd4:    rate_d[7:0]   = data_byte;
						5'd5:    rate_d[15:8]  = data_byte;
						5'd6:    rate_d[23:16] = data_byte;
						5'd7:    rate_d[31:24] = data_byte;
						5'd14:   bits_d[7:0]   = data_byte;
						5'd15:   bits_d[15:8]  = data_byte;
						default: ;
					endcase
				end
				pos_d   = (pos_q == POS_SAT) ? pos_q : pos_q + 5'd1;
				chunk_d = chunk_q - 32'd1;
				if (chunk_q == 32'd1) begin
					phase_d = pad_q ? PH_PAD : PH_ID;
					pos_d   = 5'd0;
				end
			end
			PH_PAD: begin
				phase_d = PH_ID;
				pos_d   = 5'd0;
			end
			PH_DATA: begin
				if (cnt_new == bps[1:0]) begin
					smp     = 1'b1;
					smp_val = smp_new;
					given_d = 1'b1;
					smp_d   = '0;
					cnt_d   = 2'd0;
				end else begin
					smp_d = smp_new;
					cnt_d = cnt_new;
				end
				chunk_d = chunk_q - 32'd1;
				if (chunk_q == 32'd1) begin
					if (smp) begin
						smp_final = 1'b1;
					end else begin
						term    = 1'b1;
						term_st = given_q ? ST_DONE : ST_EMPTY;
					end
				end
			end
			default: live = 1'b0;
		endcase

		res.status        = ST_SAMPLE;
		res.sample_value  = '0;
		res.is_float      = 1'b0;
		res.format_tag    = fmt_d;
		res.channel_count = chan_d;
		res.rate_hz       = rate_d;
		res.sample_bits   = bits_d;
		res.final_item    = 1'b0;
		res_valid         = 1'b0;

		if (live) begin
			boundary = (phase_d == PH_ID && pos_d == 5'd0) || phase_d == PH_PAD;
			if (term) begin
				res_valid      = 1'b1;
				res.status     = term_st;
				res.final_item = 1'b1;
				phase_d        = PH_IDLE;
			end else if (smp_final) begin
				res_valid        = 1'b1;
				res.sample_value = smp_val;
				res.is_float     = (fmt_q == FMT_FLOAT);
				res.final_item   = 1'b1;
				phase_d          = PH_IDLE;
			end else if (end_of_stream) begin
				res_valid      = 1'b1;
				res.status     = boundary ? ST_EMPTY : ST_TRUNCATED;
				res.final_item = 1'b1;
				phase_d        = PH_IDLE;
			end else if (smp) begin
				res_valid        = 1'b1;
				res.sample_value = smp_val;
				res.is_float     = (fmt_q == FMT_FLOAT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			pos_q      <= '0;
			pad_q      <= 1'b0;
			chunk_q    <= '0;
			tag_q      <= '0;
			have_fmt_q <= 1'b0;
			fmt_q      <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			smp_q      <= '0;
			cnt_q      <= '0;
			given_q    <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			pad_q      <= pad_d;
			chunk_q    <= chunk_d;
			tag_q      <= tag_d;
			have_fmt_q <= have_fmt_d;
			fmt_q      <= fmt_d;
			chan_q     <= chan_d;
			rate_q     <= rate_d;
			bits_q     <= bits_d;
			smp_q      <= smp_d;
			cnt_q      <= cnt_d;
			given_q    <= given_d;
		end
	end

endmodule

@@ hw/rtl/wsp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsp_out_reg import wsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_res,
	input  logic    stall,
	output logic    valid,
	output logic    busy,
	output result_t res
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign valid = valid_q;
	assign busy  = valid_q && stall;
	assign res   = res_q;

endmodule
